// ===== rtl/hfa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hfa_pkg
// Shared types and constants of the hole fit allocator.
// ----------------------------------------------------------------------------
package hfa_pkg;

    localparam int MAX_BLOCKS_DEF = 16;
    localparam int ADDR_BITS_DEF  = 16;
    localparam int ID_BITS_DEF    = 8;

    localparam int FUNC_BITS   = 2;
    localparam int MODE_BITS   = 2;
    localparam int STATUS_BITS = 3;

    typedef enum logic [FUNC_BITS-1:0] {
        FN_ALLOC   = 2'd0,
        FN_FREE    = 2'd1,
        FN_COMPACT = 2'd2,
        FN_CLEAR   = 2'd3
    } func_t;

    typedef enum logic [MODE_BITS-1:0] {
        FIT_FIRST  = 2'd0,
        FIT_BEST   = 2'd1,
        FIT_WORST  = 2'd2,
        FIT_UNUSED = 2'd3
    } fit_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_NO_HOLE   = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_EMPTY     = 3'd5,
        ST_FULL      = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DUP_RD,
        S_DUP_CHK,
        S_HOLE_RD,
        S_HOLE_CHK,
        S_PLACE,
        S_INS_RD,
        S_INS_WR,
        S_FREE_RD,
        S_FREE_CHK,
        S_SHL_RD,
        S_SHL_WR,
        S_CMP_RD,
        S_CMP_WR,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/hfa_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hfa_table
// Block table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hfa_table #(
    parameter int MAX_BLOCKS = hfa_pkg::MAX_BLOCKS_DEF,
    parameter int ADDR_BITS  = hfa_pkg::ADDR_BITS_DEF,
    parameter int ID_BITS    = hfa_pkg::ID_BITS_DEF,
    localparam int IW        = $clog2(MAX_BLOCKS),
    localparam int EW        = ID_BITS + 2 * ADDR_BITS
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [IW-1:0] wr_idx,
    input  wire logic [EW-1:0] wr_data,
    input  wire logic [IW-1:0] rd_idx,
    output logic      [EW-1:0] rd_data
);

    logic [EW-1:0] mem [MAX_BLOCKS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_idx];
    end

endmodule
`default_nettype wire

// ===== rtl/hole_fit_allocator_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hole_fit_allocator_top
// Address-ordered block allocator with first, best and worst fit.
// ----------------------------------------------------------------------------
// One item at a time. The table sits in one memory with a registered read
// port, so every entry visited takes a read state and then a check or write
// state. An allocate runs a duplicate scan, a hole scan, a step to pick the
// hole and an insertion in which the entries from the new slot upward move
// up by one. The next item is accepted once the result has been taken. A
// write of memory_size empties the table and is taken ahead of an item
// offered in the same cycle.
module hole_fit_allocator_top #(
    parameter int MAX_BLOCKS = hfa_pkg::MAX_BLOCKS_DEF,
    parameter int ADDR_BITS  = hfa_pkg::ADDR_BITS_DEF,
    parameter int ID_BITS    = hfa_pkg::ID_BITS_DEF,
    localparam int IW        = $clog2(MAX_BLOCKS),
    localparam int CW        = $clog2(MAX_BLOCKS + 1),
    localparam int EW        = ID_BITS + 2 * ADDR_BITS,
    localparam int IN_RAW    = hfa_pkg::FUNC_BITS + ID_BITS + ADDR_BITS + hfa_pkg::MODE_BITS,
    localparam int IN_W      = ((IN_RAW + 7) / 8) * 8,
    localparam int OUT_RAW   = hfa_pkg::STATUS_BITS + ADDR_BITS + CW,
    localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [ADDR_BITS-1:0] cfg_data,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // func, block_id, block_size, fit_mode
    input  wire logic [IN_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // status, start_address, blocks_in_use
    output logic      [OUT_W-1:0] m_tdata
);

    localparam int P_ID   = hfa_pkg::FUNC_BITS;
    localparam int P_SIZE = P_ID + ID_BITS;
    localparam int P_MODE = P_SIZE + ADDR_BITS;
    localparam int AW1    = ADDR_BITS + 1;

    hfa_pkg::state_t state_reg, state_next;

    logic [ADDR_BITS-1:0] msize_reg;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic                 placed_reg, placed_next;
    logic [ID_BITS-1:0]   id_reg;
    logic [ADDR_BITS-1:0] size_reg;
    hfa_pkg::fit_t        mode_reg;
    logic [ADDR_BITS-1:0] from_reg, from_next;
    logic [AW1-1:0]       blen_reg, blen_next;
    logic                 found_reg, found_next;
    logic [ADDR_BITS-1:0] at_reg, at_next;
    logic [ADDR_BITS-1:0] place_reg, place_next;
    logic [EW-1:0]        hold_reg, hold_next;
    hfa_pkg::status_t     st_reg, st_next;
    logic [ADDR_BITS-1:0] where_reg, where_next;
    logic                 ovalid_reg;
    logic [OUT_RAW-1:0]   odata_reg;

    logic          wr_en;
    logic [IW-1:0] wr_idx, rd_idx;
    logic [EW-1:0] wr_data, rd_data;
    logic [CW-1:0] rd_sel;

    logic [ID_BITS-1:0]   e_id;
    logic [ADDR_BITS-1:0] e_start, e_end;
    assign e_id    = rd_data[ID_BITS-1:0];
    assign e_start = rd_data[ID_BITS +: ADDR_BITS];
    assign e_end   = rd_data[ID_BITS + ADDR_BITS +: ADDR_BITS];

    hfa_table #(
        .MAX_BLOCKS(MAX_BLOCKS), .ADDR_BITS(ADDR_BITS), .ID_BITS(ID_BITS)
    ) u_table (
        .aclk(aclk), .wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data),
        .rd_idx(rd_idx), .rd_data(rd_data)
    );

    logic idle;
    assign idle      = (state_reg == hfa_pkg::S_IDLE);
    // a configuration write goes first
    assign s_tready  = idle && !ovalid_reg && !cfg_valid;
    assign cfg_ready = idle && !ovalid_reg;
    assign m_tvalid  = ovalid_reg;
    assign m_tdata   = OUT_W'(odata_reg);

    // hole scan helpers
    logic                 last_hole;
    logic [ADDR_BITS-1:0] hole_to;
    logic signed [AW1:0]  hlen;
    logic                 fits;
    assign last_hole = (idx_reg == count_reg);
    assign hole_to   = last_hole ? msize_reg : e_start;
    assign hlen      = $signed({2'b00, hole_to}) - $signed({2'b00, from_reg});
    assign fits      = (hlen >= $signed({2'b00, size_reg}));

    // new entry goes at idx: before entry zero only when strictly lower,
    // otherwise at the first later entry whose start is not lower
    logic ins_here;
    assign ins_here = (idx_reg == count_reg) ||
                      ((idx_reg == '0) ? (place_reg < e_start) : !(e_start < place_reg));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            hfa_pkg::S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    unique case (hfa_pkg::func_t'(s_tdata[hfa_pkg::FUNC_BITS-1:0]))
                        hfa_pkg::FN_ALLOC: begin
                            if (s_tdata[P_SIZE +: ADDR_BITS] > msize_reg)
                                state_next = hfa_pkg::S_DONE;
                            else
                                state_next = hfa_pkg::S_DUP_RD;
                        end
                        hfa_pkg::FN_FREE:    state_next = hfa_pkg::S_FREE_RD;
                        hfa_pkg::FN_COMPACT: state_next = hfa_pkg::S_CMP_RD;
                        hfa_pkg::FN_CLEAR:   state_next = hfa_pkg::S_DONE;
                        default:             state_next = hfa_pkg::S_DONE;
                    endcase
                end
            end
            hfa_pkg::S_DUP_RD: begin
                if (idx_reg == count_reg)
                    state_next = (count_reg >= CW'(MAX_BLOCKS)) ? hfa_pkg::S_DONE
                                                              : hfa_pkg::S_HOLE_RD;
                else
                    state_next = hfa_pkg::S_DUP_CHK;
            end
            hfa_pkg::S_DUP_CHK:
                state_next = (e_id == id_reg) ? hfa_pkg::S_DONE : hfa_pkg::S_DUP_RD;
            hfa_pkg::S_HOLE_RD:  state_next = hfa_pkg::S_HOLE_CHK;
            hfa_pkg::S_HOLE_CHK: begin
                if (last_hole && from_reg >= msize_reg)
                    state_next = hfa_pkg::S_PLACE;
                else if (fits && mode_reg == hfa_pkg::FIT_FIRST)
                    state_next = hfa_pkg::S_PLACE;
                else if (last_hole)
                    state_next = hfa_pkg::S_PLACE;
                else
                    state_next = hfa_pkg::S_HOLE_RD;
            end
            hfa_pkg::S_PLACE:
                state_next = found_reg ? hfa_pkg::S_INS_RD : hfa_pkg::S_DONE;
            hfa_pkg::S_INS_RD: state_next = hfa_pkg::S_INS_WR;
            hfa_pkg::S_INS_WR:
                state_next = (idx_reg == count_reg) ? hfa_pkg::S_DONE : hfa_pkg::S_INS_RD;
            hfa_pkg::S_FREE_RD:
                state_next = (idx_reg == count_reg) ? hfa_pkg::S_DONE
                                                   : hfa_pkg::S_FREE_CHK;
            hfa_pkg::S_FREE_CHK:
                state_next = (e_id == id_reg) ? hfa_pkg::S_SHL_RD : hfa_pkg::S_FREE_RD;
            hfa_pkg::S_SHL_RD:
                state_next = (idx_reg + CW'(1) >= count_reg) ? hfa_pkg::S_DONE
                                                           : hfa_pkg::S_SHL_WR;
            hfa_pkg::S_SHL_WR: state_next = hfa_pkg::S_SHL_RD;
            hfa_pkg::S_CMP_RD:
                state_next = (idx_reg == count_reg) ? hfa_pkg::S_DONE
                                                   : hfa_pkg::S_CMP_WR;
            hfa_pkg::S_CMP_WR: state_next = hfa_pkg::S_CMP_RD;
            hfa_pkg::S_DONE:   state_next = hfa_pkg::S_IDLE;
            default:           state_next = hfa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        placed_next = placed_reg;
        from_next   = from_reg;
        blen_next   = blen_reg;
        found_next  = found_reg;
        at_next     = at_reg;
        place_next  = place_reg;
        hold_next   = hold_reg;
        st_next     = st_reg;
        where_next  = where_reg;
        wr_en       = 1'b0;
        wr_idx      = '0;
        wr_data     = '0;
        rd_sel      = idx_reg;
        unique case (state_reg)
            hfa_pkg::S_IDLE: begin
                idx_next   = '0;
                from_next  = '0;
                found_next = 1'b0;
                at_next    = '0;
                where_next = '0;
                st_next    = hfa_pkg::ST_OK;
                blen_next  = {1'b0, msize_reg} + AW1'(1);
                if (cfg_valid && cfg_ready) count_next = '0;
                if (s_tvalid && s_tready) begin
                    unique case (hfa_pkg::func_t'(s_tdata[hfa_pkg::FUNC_BITS-1:0]))
                        hfa_pkg::FN_ALLOC: begin
                            if (s_tdata[P_SIZE +: ADDR_BITS] > msize_reg)
                                st_next = hfa_pkg::ST_TOO_LARGE;
                        end
                        hfa_pkg::FN_FREE:    st_next = hfa_pkg::ST_NOT_FOUND;
                        hfa_pkg::FN_COMPACT: begin
                            if (count_reg == '0) st_next = hfa_pkg::ST_EMPTY;
                        end
                        hfa_pkg::FN_CLEAR:   count_next = '0;
                        default: ;
                    endcase
                end
            end
            hfa_pkg::S_DUP_RD: begin
                if (idx_reg == count_reg) begin
                    idx_next = '0;
                    if (count_reg >= CW'(MAX_BLOCKS)) st_next = hfa_pkg::ST_FULL;
                end
            end
            hfa_pkg::S_DUP_CHK: begin
                idx_next = idx_reg + CW'(1);
                if (e_id == id_reg) st_next = hfa_pkg::ST_DUPLICATE;
            end
            hfa_pkg::S_HOLE_RD: ;
            hfa_pkg::S_HOLE_CHK: begin
                if (!(last_hole && from_reg >= msize_reg) && fits) begin
                    unique case (mode_reg)
                        hfa_pkg::FIT_FIRST: begin
                            found_next = 1'b1;
                            at_next    = from_reg;
                        end
                        hfa_pkg::FIT_BEST: begin
                            if (hlen < $signed({1'b0, blen_reg})) begin
                                blen_next  = hlen[AW1-1:0];
                                found_next = 1'b1;
                                at_next    = from_reg;
                            end
                        end
                        hfa_pkg::FIT_WORST: begin
                            if (hlen > $signed({1'b0, blen_reg}) ||
                                (!found_reg && hlen > 0)) begin
                                blen_next  = hlen[AW1-1:0];
                                found_next = 1'b1;
                                at_next    = from_reg;
                            end
                        end
                        default: ;
                    endcase
                end
                if (!last_hole) from_next = e_end;
                idx_next = idx_reg + CW'(1);
            end
            hfa_pkg::S_PLACE: begin
                // walk up from entry zero, carrying each displaced entry one slot up
                if (!found_reg) st_next = hfa_pkg::ST_NO_HOLE;
                where_next  = found_reg ? at_reg : '0;
                place_next  = at_reg;
                placed_next = 1'b0;
                idx_next    = '0;
            end
            hfa_pkg::S_INS_RD: ;
            hfa_pkg::S_INS_WR: begin
                // entry idx is in rd_data
                if (placed_reg || ins_here) begin
                    wr_en  = 1'b1;
                    wr_idx = idx_reg[IW-1:0];
                    if (placed_reg)
                        wr_data = hold_reg;
                    else
                        wr_data = {place_reg + size_reg, place_reg, id_reg};
                    hold_next   = rd_data;
                    placed_next = 1'b1;
                end
                idx_next = idx_reg + CW'(1);
                if (idx_reg == count_reg) count_next = count_reg + CW'(1);
            end
            hfa_pkg::S_FREE_RD: ;
            hfa_pkg::S_FREE_CHK: begin
                if (e_id == id_reg) begin
                    st_next  = hfa_pkg::ST_OK;
                    rd_sel   = idx_reg + CW'(1);
                end else begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            hfa_pkg::S_SHL_RD: begin
                rd_sel = idx_reg + CW'(1);
                if (idx_reg + CW'(1) >= count_reg) count_next = count_reg - CW'(1);
            end
            hfa_pkg::S_SHL_WR: begin
                wr_en    = 1'b1;
                wr_idx   = idx_reg[IW-1:0];
                wr_data  = rd_data;
                idx_next = idx_reg + CW'(1);
                rd_sel   = idx_reg + CW'(2);
            end
            hfa_pkg::S_CMP_RD: ;
            hfa_pkg::S_CMP_WR: begin
                wr_en     = 1'b1;
                wr_idx    = idx_reg[IW-1:0];
                wr_data   = {from_reg + (e_end - e_start), from_reg, e_id};
                from_next = from_reg + (e_end - e_start);
                idx_next  = idx_reg + CW'(1);
            end
            hfa_pkg::S_DONE: ;
            default: ;
        endcase
        rd_idx = rd_sel[IW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= hfa_pkg::S_IDLE;
            count_reg  <= '0;
            msize_reg  <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
                msize_reg <= cfg_data;
            if (state_reg == hfa_pkg::S_DONE)
                ovalid_reg <= 1'b1;
            else if (m_tready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        placed_reg <= placed_next;
        from_reg   <= from_next;
        blen_reg   <= blen_next;
        found_reg  <= found_next;
        at_reg     <= at_next;
        place_reg  <= place_next;
        hold_reg   <= hold_next;
        st_reg     <= st_next;
        where_reg  <= where_next;
        if (s_tvalid && s_tready) begin
            id_reg   <= s_tdata[P_ID +: ID_BITS];
            size_reg <= s_tdata[P_SIZE +: ADDR_BITS];
            mode_reg <= hfa_pkg::fit_t'(s_tdata[P_MODE +: hfa_pkg::MODE_BITS]);
        end
        if (state_reg == hfa_pkg::S_DONE)
            odata_reg <= {count_reg, where_reg, st_reg};
    end

    // block count stays within the table size
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_BLOCKS))
        else $error("block count beyond table size");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hfa_pkg::S_DONE) |=> m_tvalid)
        else $error("result not presented");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !idle)
        else $error("table written while idle");

endmodule
`default_nettype wire

// ===== tb/hole_fit_allocator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hole_fit_allocator_top_tb
// Drives allocate, free, compact and clear items into the allocator with
// random gaps and output stalls, predicts each result from a table model
// kept here, and compares status, start address and block count.
// ----------------------------------------------------------------------------
module hole_fit_allocator_top_tb;

    localparam int NB      = 16;
    localparam int IN_W    = 32;
    localparam int OUT_W   = 24;
    localparam int MAX_CYC = 3000000;

    typedef struct packed {
        hfa_pkg::status_t status;
        logic [15:0]      addr;
        logic [4:0]       count;
    } alloc_result_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [15:0]      cfg_data = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    // func, block_id, block_size, fit_mode
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    // status, start_address, blocks_in_use
    logic [OUT_W-1:0] m_tdata;

    hole_fit_allocator_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // table model
    logic [7:0]    tbl_id [NB];
    logic [15:0]   tbl_lo [NB];
    logic [15:0]   tbl_hi [NB];
    int            tbl_n;
    logic [15:0]   mem_size;
    alloc_result_t pending_results[$];
    bit            failed = 0;
    int            cycles = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic bit id_in_table(logic [7:0] id);
        for (int i = 0; i < tbl_n; i++) if (tbl_id[i] == id) return 1;
        return 0;
    endfunction

    function automatic void table_insert(logic [7:0] id, logic [15:0] s, logic [15:0] len);
        int pos;
        if (tbl_n == 0 || s < tbl_lo[0]) pos = 0;
        else begin
            pos = 1;
            while (pos < tbl_n && tbl_lo[pos] < s) pos++;
        end
        for (int k = tbl_n; k > pos; k--) begin
            tbl_id[k] = tbl_id[k-1]; tbl_lo[k] = tbl_lo[k-1]; tbl_hi[k] = tbl_hi[k-1];
        end
        tbl_id[pos] = id;
        tbl_lo[pos] = s;
        tbl_hi[pos] = s + len;
        tbl_n++;
    endfunction

    function automatic alloc_result_t predict_op(hfa_pkg::func_t fn, logic [7:0] id,
                                                 logic [15:0] size, hfa_pkg::fit_t mode);
        alloc_result_t r;
        longint best_len, worst_len, from, to, len;
        logic [15:0] best_at, worst_at, at;
        bit found;
        r.status = hfa_pkg::ST_OK;
        r.addr = '0;
        case (fn)
            hfa_pkg::FN_ALLOC: begin
                best_len = longint'(mem_size) + 1; worst_len = 0;
                best_at = 0; worst_at = 0; from = 0; found = 0;
                if (size > mem_size) r.status = hfa_pkg::ST_TOO_LARGE;
                else if (id_in_table(id)) r.status = hfa_pkg::ST_DUPLICATE;
                else if (tbl_n >= NB) r.status = hfa_pkg::ST_FULL;
                else begin
                    r.status = hfa_pkg::ST_NO_HOLE;
                    for (int i = 0; i <= tbl_n && !found; i++) begin
                        if (i == tbl_n) begin
                            if (from >= mem_size) break;
                            to = mem_size;
                        end else to = tbl_lo[i];
                        len = to - from;
                        if (len >= longint'(size)) begin
                            if (mode == hfa_pkg::FIT_FIRST) begin
                                r.addr = from[15:0]; found = 1;
                            end
                            if (mode == hfa_pkg::FIT_BEST && len < best_len) begin
                                best_len = len; best_at = from[15:0];
                            end
                            if (mode == hfa_pkg::FIT_WORST && len > worst_len) begin
                                worst_len = len; worst_at = from[15:0];
                            end
                        end
                        if (i < tbl_n) from = tbl_hi[i];
                    end
                    if (!found && mode == hfa_pkg::FIT_BEST &&
                        best_len != longint'(mem_size) + 1) begin
                        r.addr = best_at; found = 1;
                    end
                    if (!found && mode == hfa_pkg::FIT_WORST && worst_len != 0) begin
                        r.addr = worst_at; found = 1;
                    end
                    if (found) begin
                        r.status = hfa_pkg::ST_OK;
                        table_insert(id, r.addr, size);
                    end
                end
            end
            hfa_pkg::FN_FREE: begin
                r.status = hfa_pkg::ST_NOT_FOUND;
                for (int i = 0; i < tbl_n; i++) begin
                    if (tbl_id[i] == id) begin
                        for (int k = i; k + 1 < tbl_n; k++) begin
                            tbl_id[k] = tbl_id[k+1]; tbl_lo[k] = tbl_lo[k+1];
                            tbl_hi[k] = tbl_hi[k+1];
                        end
                        tbl_n--;
                        r.status = hfa_pkg::ST_OK;
                        break;
                    end
                end
            end
            hfa_pkg::FN_COMPACT: begin
                if (tbl_n == 0) r.status = hfa_pkg::ST_EMPTY;
                else begin
                    at = 0;
                    for (int i = 0; i < tbl_n; i++) begin
                        len = 16'(tbl_hi[i] - tbl_lo[i]);
                        tbl_lo[i] = at;
                        tbl_hi[i] = at + 16'(len);
                        at = tbl_hi[i];
                    end
                end
            end
            default: tbl_n = 0;
        endcase
        r.count = 5'(tbl_n);
        return r;
    endfunction

    // result checker
    always @(posedge aclk) begin
        alloc_result_t got, exp;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = hfa_pkg::status_t'(m_tdata[2:0]);
            got.addr = m_tdata[18:3];
            got.count = m_tdata[23:19];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                failed = 1;
            end else begin
                exp = pending_results.pop_front();
                if (got.status !== exp.status) begin
                    $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
                    failed = 1;
                end
                if (got.addr !== exp.addr) begin
                    $display("%0t: start exp %0d got %0d", $time, exp.addr, got.addr);
                    failed = 1;
                end
                if (got.count !== exp.count) begin
                    $display("%0t: count exp %0d got %0d", $time, exp.count, got.count);
                    failed = 1;
                end
            end
        end
    end

    // output stall pattern: a random wait before each result, with calm stretches
    bit rx_calm = 0;
    initial begin
        int w;
        @(posedge aclk iff aresetn);
        forever begin
            w = rx_calm ? 0 : $urandom_range(0, 19);
            if ($urandom_range(0, 99) == 0) rx_calm = ~rx_calm;
            repeat (w) begin
                m_tready <= 1'b0;
                @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk iff m_tvalid);
        end
    end

    bit tx_calm = 0;

    // tvalid stays high into the next item when it follows with no gap
    task automatic send_op(hfa_pkg::func_t fn, logic [7:0] id, logic [15:0] size,
                           hfa_pkg::fit_t mode);
        int w;
        w = tx_calm ? 0 : $urandom_range(0, 19);
        if (w > 0) begin
            s_tvalid <= 1'b0;
            repeat (w) @(posedge aclk);
        end
        s_tdata <= {4'd0, mode, size, id, fn};
        s_tvalid <= 1'b1;
        @(posedge aclk iff s_tready);
        pending_results.push_back(predict_op(fn, id, size, mode));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk iff pending_results.size() == 0);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_mem_size(logic [15:0] v);
        drain();
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge aclk iff cfg_ready);
        cfg_valid <= 1'b0;
        mem_size = v;
        tbl_n = 0;
    endtask

    task automatic test_directed();
        write_mem_size(16'd100);
        send_op(hfa_pkg::FN_COMPACT, 8'd0, 16'd0, hfa_pkg::FIT_FIRST);    // empty compact
        send_op(hfa_pkg::FN_FREE, 8'd5, 16'd0, hfa_pkg::FIT_FIRST);       // free on empty
        send_op(hfa_pkg::FN_ALLOC, 8'd1, 16'd101, hfa_pkg::FIT_FIRST);    // too large
        send_op(hfa_pkg::FN_ALLOC, 8'd1, 16'd20, hfa_pkg::FIT_FIRST);
        send_op(hfa_pkg::FN_ALLOC, 8'd1, 16'd5, hfa_pkg::FIT_FIRST);      // duplicate
        send_op(hfa_pkg::FN_ALLOC, 8'd2, 16'd30, hfa_pkg::FIT_BEST);
        send_op(hfa_pkg::FN_ALLOC, 8'd3, 16'd0, hfa_pkg::FIT_WORST);      // zero size
        send_op(hfa_pkg::FN_FREE, 8'd1, 16'd0, hfa_pkg::FIT_FIRST);
        send_op(hfa_pkg::FN_ALLOC, 8'd4, 16'd10, hfa_pkg::FIT_BEST);
        send_op(hfa_pkg::FN_ALLOC, 8'd5, 16'd10, hfa_pkg::FIT_WORST);
        send_op(hfa_pkg::FN_ALLOC, 8'd6, 16'd10, hfa_pkg::FIT_UNUSED);    // unused mode
        send_op(hfa_pkg::FN_ALLOC, 8'd255, 16'd100, hfa_pkg::FIT_FIRST);  // no hole
        send_op(hfa_pkg::FN_COMPACT, 8'd0, 16'd0, hfa_pkg::FIT_FIRST);
        send_op(hfa_pkg::FN_ALLOC, 8'd7, 16'd0, hfa_pkg::FIT_FIRST);      // zero size at end
        send_op(hfa_pkg::FN_CLEAR, 8'd0, 16'd0, hfa_pkg::FIT_FIRST);
        send_op(hfa_pkg::FN_CLEAR, 8'd255, 16'hffff, hfa_pkg::FIT_UNUSED);
        write_mem_size(16'hffff);
        send_op(hfa_pkg::FN_ALLOC, 8'd9, 16'hffff, hfa_pkg::FIT_WORST);
        send_op(hfa_pkg::FN_ALLOC, 8'd10, 16'd0, hfa_pkg::FIT_WORST);     // zero hole, worst
        send_op(hfa_pkg::FN_ALLOC, 8'd11, 16'd0, hfa_pkg::FIT_BEST);
        write_mem_size(16'd0);
        send_op(hfa_pkg::FN_ALLOC, 8'd0, 16'd0, hfa_pkg::FIT_FIRST);
        send_op(hfa_pkg::FN_ALLOC, 8'd1, 16'd1, hfa_pkg::FIT_FIRST);
    endtask

    // fill the table to the limit
    task automatic test_table_full();
        write_mem_size(16'd64);
        for (int i = 0; i < NB + 2; i++)
            send_op(hfa_pkg::FN_ALLOC, 8'(i), 16'd2, hfa_pkg::FIT_FIRST);
        drain();
    endtask

    task automatic test_random(int n);
        logic [15:0] sz;
        hfa_pkg::func_t fn;
        int r;
        for (int i = 0; i < n; i++) begin
            if (i % 300 == 0) begin
                case ($urandom_range(0, 3))
                    0: write_mem_size(16'($urandom_range(0, 40)));
                    1: write_mem_size(16'hffff);
                    default: write_mem_size(16'($urandom_range(50, 2000)));
                endcase
            end
            if ($urandom_range(0, 199) == 0) tx_calm = ~tx_calm;
            r = $urandom_range(0, 99);
            fn = r < 55 ? hfa_pkg::FN_ALLOC : r < 85 ? hfa_pkg::FN_FREE :
                 r < 97 ? hfa_pkg::FN_COMPACT : hfa_pkg::FN_CLEAR;
            case ($urandom_range(0, 9))
                0: sz = 16'($urandom());
                1: sz = 16'd0;
                default: sz = 16'($urandom_range(0, (mem_size >> 3) + 1));
            endcase
            send_op(fn, $urandom_range(0, 9) == 0 ? 8'($urandom()) : 8'($urandom_range(0, 23)),
                    sz, hfa_pkg::fit_t'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2)));
        end
    endtask

    initial begin
        mem_size = 0;
        tbl_n = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_table_full();
        test_random(1820);
        drain();
        if (!failed) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/hfa_pkg.sv
rtl/hfa_table.sv
rtl/hole_fit_allocator_top.sv
tb/hole_fit_allocator_top_tb.sv
